/* hw/rtl/xrf_pkg.sv */
`default_nettype none
package xrf_pkg;

  // Input item: action plus the received byte
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  // Result item, one per input item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       is_end;
    logic [1:0] flow_request;
    logic       overflow;
    logic [3:0] fill_count;
  } out_item_t;

  // Configuration bundle from the register file to the sequencer
  typedef struct packed {
    logic [3:0] upper_limit;
    logic [3:0] lower_limit;
    logic [7:0] eof_code;
  } cfg_t;

  // Action codes
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_CONSUME = 1'b1;

  // Flow request codes
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_XOFF = 2'd1;
  localparam logic [1:0] REQ_XON  = 2'd2;

  // Register indexes (word address)
  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_EOF   = 2'd2;

  // Register reset values
  localparam logic [3:0] UPPER_RESET = 4'd6;
  localparam logic [3:0] LOWER_RESET = 4'd2;
  localparam logic [7:0] EOF_RESET   = 8'd26;

  // Byte classification constants
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // A byte survives the consume scan when its code is 32 or above, or it is CR, LF or end-of-file
  function automatic logic byte_kept(input logic [7:0] b, input logic [7:0] eof);
    byte_kept = (b >= CTRL_LIMIT) || (b == CODE_CR) || (b == CODE_LF) || (b == eof);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/xrf_mem.sv */
`default_nettype none
module xrf_mem #(
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [7:0]               wr_data_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [7:0]               rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, address sampled every cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* hw/rtl/xrf_ctrl.sv */
`default_nettype none
module xrf_ctrl import xrf_pkg::*; #(
  parameter int Depth = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire in_item_t                 in_data_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output out_item_t                     res_data_o,
  output logic                          wr_en_o,
  output logic      [$clog2(Depth)-1:0] wr_addr_o,
  output logic      [7:0]               wr_data_o,
  output logic      [$clog2(Depth)-1:0] rd_addr_o,
  input  wire logic [7:0]               rd_data_i
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int CmpW = (CntW > 4) ? CntW : 4;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            paused_q, paused_d;
  out_item_t       res_q, res_d;

  logic            accept;
  logic [CntW-1:0] cnt_inc, cnt_dec;
  logic            full;
  logic            kept;
  logic            scan_done;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = (cnt_q == FullCnt);
  assign cnt_inc = cnt_q + CntW'(1);
  assign cnt_dec = cnt_q - CntW'(1);

  // Compare unit: classify the byte at the read head
  assign kept      = byte_kept(rd_data_i, cfg_i.eof_code);
  assign scan_done = kept || (cnt_dec == '0);

  // Memory ports
  assign wr_en_o   = accept && (in_data_i.action == ACT_RECEIVE) && !full;
  assign wr_addr_o = wr_idx_q;
  assign wr_data_o = in_data_i.in_byte;
  assign rd_addr_o = rd_idx_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_data_o  = res_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    cnt_d    = cnt_q;
    paused_d = paused_q;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          if (in_data_i.action == ACT_RECEIVE) begin
            if (full) begin
              res_d.overflow = 1'b1;
            end else begin
              wr_idx_d = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + IdxW'(1);
              cnt_d    = cnt_inc;
            end
            if ((CmpW'(cnt_d) > CmpW'(cfg_i.upper_limit)) && !paused_q) begin
              paused_d           = 1'b1;
              res_d.flow_request = REQ_XOFF;
            end
            res_d.fill_count = 4'(cnt_d);
            state_d          = ST_DONE;
          end else if (cnt_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        // pop one byte
        rd_idx_d = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + IdxW'(1);
        cnt_d    = cnt_dec;
        if (scan_done) begin
          res_d.out_byte  = rd_data_i;
          res_d.out_valid = 1'b1;
          res_d.is_end    = (rd_data_i == cfg_i.eof_code);
          if ((CmpW'(cnt_dec) < CmpW'(cfg_i.lower_limit)) && paused_q) begin
            paused_d           = 1'b0;
            res_d.flow_request = REQ_XON;
          end
          res_d.fill_count = 4'(cnt_dec);
          state_d          = ST_DONE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // read data for the new head lands next cycle
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      cnt_q    <= '0;
      paused_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      cnt_q    <= cnt_d;
      paused_q <= paused_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/xon_xoff_receive_fifo_core.sv */
// Receive ring buffer with XON/XOFF flow control.
// Input channel (in_valid_i/in_ready_o/in_data_i): each request is either a
// receive (store in_byte) or a consume (pop bytes, dropping control bytes
// other than CR, LF and the end-of-file code, until a kept byte or empty).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result per
// request, carrying the byte, end flag, XON/XOFF request, overflow and count.
// A receive or an empty consume goes to the DONE state and then into the
// output register; a consume pops its bytes in the CHECK state, each further
// pop waiting in WAIT on the registered read of the byte memory.
// One request is in flight at a time: the next request is taken only after
// the result moves into the output register. in_ready_o rises again as soon
// as it does, so a new request is taken while a result still waits there.
// If the receiver stalls with a result waiting, the next result is held
// inside and input is refused until it moves.
// Reset empties the buffer, turns flow on and restores the registers
// (upper 6, lower 2, end-of-file 26); no memory clearing is needed.
// APB registers: 0x0 upper limit, 0x4 lower limit, 0x8 end-of-file code.
`default_nettype none
module xon_xoff_receive_fifo_core import xrf_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic           pready
);

  localparam int IdxW = $clog2(DEPTH);

  cfg_t            cfg_q, cfg_d;
  logic            cfg_wr;
  logic            res_valid, res_ready;
  out_item_t       res_data;
  logic            out_valid_q;
  out_item_t       out_data_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_UPPER: cfg_d.upper_limit = pwdata[3:0];
        REG_LOWER: cfg_d.lower_limit = pwdata[3:0];
        REG_EOF:   cfg_d.eof_code    = pwdata[7:0];
        default:   cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_limit <= UPPER_RESET;
      cfg_q.lower_limit <= LOWER_RESET;
      cfg_q.eof_code    <= EOF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_UPPER: prdata = {28'd0, cfg_q.upper_limit};
      REG_LOWER: prdata = {28'd0, cfg_q.lower_limit};
      REG_EOF:   prdata = {24'd0, cfg_q.eof_code};
      default:   prdata = '0;
    endcase
  end

  // Sequencer
  xrf_ctrl #(
    .Depth(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // Byte store
  xrf_mem #(
    .Depth(DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import xrf_pkg::*;

  localparam int DEPTH       = 8;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_REQS  = 122;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = 40;

  // Clock, reset and block signals
  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Pending requests and predicted results
  in_item_t    rx_reqs_q[$];
  out_item_t   rx_results_q[$];
  int          errors = 0;

  // Predictor state
  logic [7:0]  m_store [DEPTH];
  int          m_rd     = 0;
  int          m_wr     = 0;
  int          m_count  = 0;
  logic        m_paused = 1'b0;
  logic [3:0]  m_upper  = UPPER_RESET;
  logic [3:0]  m_lower  = LOWER_RESET;
  logic [7:0]  m_eof    = EOF_RESET;

  // Sender and receiver pacing
  int          burst_left = 1;
  int          gap_left   = 0;
  int          stall_mode = 0;
  int          mode_left  = 0;
  logic [1:0]  cyc_cnt    = '0;
  int          idle_cycles = 0;

  always #6 clk = ~clk;

  xon_xoff_receive_fifo_core #(.DEPTH(DEPTH)) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predict the result of one request and advance the buffer state
  function automatic out_item_t rx_fifo_step(input in_item_t req);
    out_item_t  r;
    logic [7:0] cur;
    logic       done;
    r = '0;
    if (req.action == ACT_RECEIVE) begin
      if (m_count >= DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        m_store[m_wr] = req.in_byte;
        m_wr = (m_wr + 1) % DEPTH;
        m_count++;
      end
      // XOFF check runs even when the byte was dropped
      if (m_count > int'(m_upper) && !m_paused) begin
        m_paused = 1'b1;
        r.flow_request = REQ_XOFF;
      end
    end else if (m_count > 0) begin
      cur  = '0;
      done = 1'b0;
      // pop until a kept byte shows up or the buffer runs dry
      while (!done) begin
        cur = m_store[m_rd];
        m_rd = (m_rd + 1) % DEPTH;
        m_count--;
        done = (cur >= CTRL_LIMIT) || (cur == CODE_CR) || (cur == CODE_LF) ||
               (cur == m_eof) || (m_count == 0);
      end
      r.out_byte  = cur;
      r.out_valid = 1'b1;
      r.is_end    = (cur == m_eof);
      if (m_count < int'(m_lower) && m_paused) begin
        m_paused = 1'b0;
        r.flow_request = REQ_XON;
      end
    end
    r.fill_count = m_count[3:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  task automatic push_req(input logic act, input logic [7:0] b);
    in_item_t it;
    it.action  = act;
    it.in_byte = b;
    rx_reqs_q.push_back(it);
  endtask

  // APB write: setup then access; register also updated in the predictor
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {$urandom_range(0, 1) ? 24'($urandom) : 24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UPPER: m_upper = val[3:0];
      REG_LOWER: m_lower = val[3:0];
      default:   m_eof   = val;
    endcase
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_drained();
    while (rx_reqs_q.size() != 0 || in_valid || rx_results_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Mostly fill/drain runs with a bias to control bytes, plus some noise
  task automatic queue_random_reqs(input int n);
    int         left;
    int         run;
    int         cls;
    logic [7:0] b;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(1'($urandom_range(0, 1)), 8'($urandom));
        left--;
      end else begin
        run = $urandom_range(1, 12);
        for (int j = 0; j < run && left > 0; j++) begin
          cls = $urandom_range(0, 9);
          if (cls < 3)
            b = 8'($urandom_range(0, 31));
          else if (cls == 3)
            case ($urandom_range(0, 2))
              0:       b = CODE_CR;
              1:       b = CODE_LF;
              default: b = m_eof;
            endcase
          else
            b = 8'($urandom);
          push_req(ACT_RECEIVE, b);
          left--;
        end
        run = $urandom_range(1, 12);
        for (int j = 0; j < run && left > 0; j++) begin
          push_req(ACT_CONSUME, 8'($urandom));
          left--;
        end
      end
    end
  endtask

  // Sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        rx_results_q.push_back(rx_fifo_step(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (rx_reqs_q.size() > 0) begin
          in_data  <= rx_reqs_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall on a changing pattern
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rx_results_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: expected none, actual %h",
                   $time, out_data);
        end else begin
          want = rx_results_q.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("out_valid", want.out_valid, out_data.out_valid);
          check_field("is_end", want.is_end, out_data.is_end);
          check_field("flow_request", want.flow_request, out_data.flow_request);
          check_field("overflow", want.overflow, out_data.overflow);
          check_field("fill_count", want.fill_count, out_data.fill_count);
        end
      end
      cyc_cnt <= cyc_cnt + 1'b1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (cyc_cnt == 2'd0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Phase sequencing
  initial begin
    logic [3:0] up_tab  [NUM_PHASES];
    logic [3:0] lo_tab  [NUM_PHASES];
    logic [7:0] eof_tab [NUM_PHASES];
    up_tab  = '{4'd6, 4'd0, 4'd8, 4'd15, 4'd3, 4'd8, 4'd0, 4'd0};
    lo_tab  = '{4'd2, 4'd0, 4'd8, 4'd15, 4'd5, 4'd0, 4'd0, 4'd0};
    eof_tab = '{8'd26, 8'd0, 8'd255, 8'd13, 8'd10, 8'd31, 8'd0, 8'd0};
    for (int p = 6; p < NUM_PHASES; p++) begin
      up_tab[p]  = 4'($urandom_range(0, 15));
      lo_tab[p]  = 4'($urandom_range(0, 15));
      eof_tab[p] = 8'($urandom);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      // first phase runs on reset values of the registers
      if (p > 0) begin
        reg_write(REG_UPPER, {4'h0, up_tab[p]});
        reg_write(REG_LOWER, {4'h0, lo_tab[p]});
        reg_write(REG_EOF, eof_tab[p]);
      end
      @(negedge clk);
      if (p == 0) begin
        // consume on empty buffer
        push_req(ACT_CONSUME, 8'hFF);
        // fill with control, CR, LF, end-of-file and printable bytes
        push_req(ACT_RECEIVE, 8'h00);
        push_req(ACT_RECEIVE, 8'h1F);
        push_req(ACT_RECEIVE, CODE_CR);
        push_req(ACT_RECEIVE, CODE_LF);
        push_req(ACT_RECEIVE, EOF_RESET);
        push_req(ACT_RECEIVE, 8'hFF);
        push_req(ACT_RECEIVE, 8'h20);
        push_req(ACT_RECEIVE, 8'h80);
        // full: dropped byte, then receive while paused after a consume
        push_req(ACT_RECEIVE, 8'h55);
        push_req(ACT_CONSUME, 8'h00);
        push_req(ACT_RECEIVE, 8'h7F);
        repeat (8) push_req(ACT_CONSUME, 8'h00);
        push_req(ACT_CONSUME, 8'h00);
        // consume that drains on control bytes only
        push_req(ACT_RECEIVE, 8'h01);
        push_req(ACT_RECEIVE, 8'h02);
        push_req(ACT_CONSUME, 8'h00);
        push_req(ACT_CONSUME, 8'h00);
      end
      queue_random_reqs(PHASE_REQS);
      // hold the sender once mid-phase until all results are back
      if (p == 3) begin
        wait_drained();
        @(negedge clk);
        queue_random_reqs(20);
      end
    end

    wait_drained();
    if (errors == 0 && rx_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* xon_xoff_receive_fifo_core.f */
hw/rtl/xrf_pkg.sv
hw/rtl/xrf_mem.sv
hw/rtl/xrf_ctrl.sv
hw/rtl/xon_xoff_receive_fifo_core.sv
sim/tb.sv
